### hw/rtl/ps2mct_pkg.sv
package ps2mct_pkg;

  // Distance from the right and bottom edges at which the cursor is clamped.
  localparam int EDGE_MARGIN = 64;
  // Coordinate that a cursor inside the edge band is sent back to.
  localparam int CLAMP_HOME  = 5;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 16;
  localparam int DELTA_W = 9;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd768;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } byte_pos_e;

  typedef enum logic [2:0] {
    G_INITIAL  = 3'd0,
    G_SELECTED = 3'd1,
    G_CLICKED  = 3'd2,
    G_DRAGGED  = 3'd3,
    G_COMPLETE = 3'd4
  } gesture_e;

  typedef enum logic [1:0] {
    K_DEFAULT  = 2'd0,
    K_HOVERING = 2'd1,
    K_SELECTED = 2'd2
  } cursor_kind_e;

endpackage

### hw/rtl/ps2_mouse_packet_cursor_tracker.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------------
// in       | input     | in_valid_i / in_ready_o   | mouse_byte_i
// out      | output    | out_valid_o / out_ready_i | buttons, moves, overflows, cursor,
//          |           |                           | cursor_kind_o, gesture_o
// cfg      | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One byte is accepted per cycle while in_ready_o is high. The output
// register loads a packet's result on the edge that accepts its third byte.
// The single output register sets the rate: input stays ready while the
// register is empty or is being drained in the same cycle.
// Reset (rst_ni low, asynchronous) clears packet framing, cursor, gesture
// machine and output valid, and loads the default screen size.

module ps2_mouse_packet_cursor_tracker
  import ps2mct_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [DIM_W-1:0]          cfg_wdata_i,

  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                mouse_byte_i,

  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      left_button_o,
  output logic                      right_button_o,
  output logic                      middle_button_o,
  output logic signed [DELTA_W-1:0] move_x_o,
  output logic signed [DELTA_W-1:0] move_y_o,
  output logic                      x_overflow_o,
  output logic                      y_overflow_o,
  output logic [COORD_W-1:0]        cursor_x_o,
  output logic [COORD_W-1:0]        cursor_y_o,
  output logic [1:0]                cursor_kind_o,
  output logic [2:0]                gesture_o
);

  // Clamp a coordinate near the far edge. The comparison is done on signed
  // values wide enough that a small screen gives a negative lower bound.
  function automatic logic [COORD_W-1:0] clamp_edge(logic [COORD_W-1:0] coord,
                                                    logic [DIM_W-1:0]   dim);
    logic signed [COORD_W+1:0] c;
    logic signed [COORD_W+1:0] dm;
    logic signed [COORD_W+1:0] lo;
    c  = signed'({2'b00, coord});
    dm = signed'({{(COORD_W+2-DIM_W){1'b0}}, dim});
    lo = dm - (COORD_W+2)'(EDGE_MARGIN);
    if (c >= lo && c <= dm) begin
      c = (COORD_W+2)'(CLAMP_HOME);
    end
    if (c >= lo) begin
      c = lo - (COORD_W+2)'(CLAMP_HOME);
    end
    return c[COORD_W-1:0];
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        REG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Packet framing and tracking state.
  byte_pos_e          pos_q, pos_d;
  logic [2:0]         buttons_q, buttons_d;
  logic [1:0]         ovf_q, ovf_d;
  logic [1:0]         sign_q, sign_d;
  logic [DELTA_W-1:0] dx_q, dx_d;
  logic [COORD_W-1:0] px_q, px_d;
  logic [COORD_W-1:0] py_q, py_d;
  gesture_e           gest_q, gest_d;
  cursor_kind_e       kind_q, kind_d;

  logic out_valid_q;
  logic in_acc;
  logic emit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  logic [DELTA_W-1:0] dy;
  logic [COORD_W-1:0] px_moved;
  logic [COORD_W-1:0] py_moved;
  logic               lb, rb, mb;

  assign dy       = {sign_q[1], mouse_byte_i};
  assign px_moved = px_q + {{(COORD_W-DELTA_W){dx_q[DELTA_W-1]}}, dx_q};
  assign py_moved = py_q - {{(COORD_W-DELTA_W){dy[DELTA_W-1]}}, dy};
  assign lb = buttons_q[0];
  assign rb = buttons_q[1];
  assign mb = buttons_q[2];

  always_comb begin
    pos_d     = pos_q;
    buttons_d = buttons_q;
    ovf_d     = ovf_q;
    sign_d    = sign_q;
    dx_d      = dx_q;
    px_d      = px_q;
    py_d      = py_q;
    gest_d    = gest_q;
    kind_d    = kind_q;
    emit      = 1'b0;
    if (in_acc) begin
      case (pos_q)
        POS_SECOND: begin
          dx_d  = {sign_q[0], mouse_byte_i};
          pos_d = POS_THIRD;
        end
        POS_THIRD: begin
          // The packet is complete: move, clamp, step the gesture machine.
          pos_d = POS_FIRST;
          emit  = 1'b1;
          px_d  = clamp_edge(px_moved, width_q);
          py_d  = clamp_edge(py_moved, height_q);
          case (gest_q)
            G_INITIAL: begin
              if (lb && !rb && !mb) begin
                gest_d = G_SELECTED;
              end
            end
            G_SELECTED: begin
              if (!lb) begin
                gest_d = G_CLICKED;
                kind_d = K_HOVERING;
              end else begin
                gest_d = G_DRAGGED;
                kind_d = K_SELECTED;
              end
            end
            G_CLICKED: begin
              if (lb) begin
                gest_d = G_COMPLETE;
              end else if (rb) begin
                gest_d = G_INITIAL;
              end
            end
            G_DRAGGED: begin
              if (!lb) begin
                gest_d = G_COMPLETE;
              end
            end
            G_COMPLETE: begin
              gest_d = G_INITIAL;
              kind_d = K_DEFAULT;
            end
            default: gest_d = G_INITIAL;
          endcase
        end
        default: begin
          // Awaiting the first byte; a byte without bit 3 set is dropped
          // so that framing can lock back onto the stream.
          if (mouse_byte_i[3]) begin
            buttons_d = mouse_byte_i[2:0];
            sign_d    = mouse_byte_i[5:4];
            ovf_d     = mouse_byte_i[7:6];
            pos_d     = POS_SECOND;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_FIRST;
      buttons_q   <= '0;
      ovf_q       <= '0;
      sign_q      <= '0;
      dx_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      gest_q      <= G_INITIAL;
      kind_q      <= K_DEFAULT;
      out_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      buttons_q <= buttons_d;
      ovf_q     <= ovf_d;
      sign_q    <= sign_d;
      dx_q      <= dx_d;
      px_q      <= px_d;
      py_q      <= py_d;
      gest_q    <= gest_d;
      kind_q    <= kind_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register; it only loads when a packet completes.
  logic [2:0]         res_btn_q;
  logic [DELTA_W-1:0] res_mx_q;
  logic [DELTA_W-1:0] res_my_q;
  logic [1:0]         res_ovf_q;
  logic [COORD_W-1:0] res_x_q;
  logic [COORD_W-1:0] res_y_q;
  logic [1:0]         res_kind_q;
  logic [2:0]         res_gest_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_btn_q  <= buttons_q;
      res_mx_q   <= dx_q;
      res_my_q   <= dy;
      res_ovf_q  <= ovf_q;
      res_x_q    <= px_d;
      res_y_q    <= py_d;
      res_kind_q <= kind_d;
      res_gest_q <= gest_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_button_o   = res_btn_q[0];
  assign right_button_o  = res_btn_q[1];
  assign middle_button_o = res_btn_q[2];
  assign move_x_o        = signed'(res_mx_q);
  assign move_y_o        = signed'(res_my_q);
  assign x_overflow_o    = res_ovf_q[0];
  assign y_overflow_o    = res_ovf_q[1];
  assign cursor_x_o      = res_x_q;
  assign cursor_y_o      = res_y_q;
  assign cursor_kind_o   = res_kind_q;
  assign gesture_o       = res_gest_q;

  // A third byte always produces a result in the next cycle.
  a_third_byte_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && pos_q == POS_THIRD |=> out_valid_q)
    else $error("third byte did not produce a result");

  // A result only appears after a third byte was accepted.
  a_result_needs_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && pos_q == POS_THIRD))
    else $error("result without a completed packet");

  // A clicked gesture always shows the hovering cursor.
  a_clicked_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gest_q == G_CLICKED |-> kind_q == K_HOVERING)
    else $error("clicked gesture with wrong cursor kind");

  // A drag always shows the selected cursor.
  a_dragged_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gest_q == G_DRAGGED |-> kind_q == K_SELECTED)
    else $error("dragged gesture with wrong cursor kind");

  // Completing a gesture returns to the initial state with the default cursor.
  a_complete_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gest_q == G_COMPLETE && emit |=> gest_q == G_INITIAL && kind_q == K_DEFAULT)
    else $error("complete gesture did not return to initial");

endmodule
